// File: design/srcm_pkg.sv
// Shared types, constants and the raised-cosine weight table of the spherical mask.
package srcm_pkg;

  localparam int MAX_SIZE        = 256;
  localparam int COS_TABLE_DEPTH = 256;

  localparam int VOX_W   = 32;
  localparam int SIZE_W  = 9;
  localparam int POS_W   = 8;
  localparam int RAD_W   = 17;
  localparam int EDGE_W  = 16;
  localparam int WGT_W   = 13;
  localparam int IDX_W   = $clog2(COS_TABLE_DEPTH + 1);
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 17;
  localparam int WSUM_W  = 40;
  localparam int WVS_W   = 64;
  localparam int REM_W   = WSUM_W + 1;
  localparam int CNT_W   = 7;

  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(4096);

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [CIDX_W-1:0] {
    REG_SIZE_X       = 3'd0,
    REG_SIZE_Y       = 3'd1,
    REG_SIZE_Z       = 3'd2,
    REG_INNER_RADIUS = 3'd3,
    REG_EDGE_WIDTH   = 3'd4,
    REG_USE_NOISE    = 3'd5
  } cfg_reg_e;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_GEOM  = 8'b0000_0010,
    ST_SQRT  = 8'b0000_0100,
    ST_IDX   = 8'b0000_1000,
    ST_MAC   = 8'b0001_0000,
    ST_AVGGO = 8'b0010_0000,
    ST_AVG   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  // Command to the shared compare/subtract unit
  typedef struct packed {
    logic              start;
    logic              sqrt;
    logic [REM_W-1:0]  rem;
    logic [63:0]       dvd;
    logic [WSUM_W-1:0] dsr;
    logic [CNT_W-1:0]  cnt;
  } srcm_cmd_t;

  typedef struct packed {
    logic             busy;
    logic [63:0]      q;
    logic [REM_W-1:0] rem;
  } srcm_sts_t;

  typedef logic [WGT_W-1:0] wtab_t [0:COS_TABLE_DEPTH];

  function automatic logic [63:0] cos_q30(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    return 64'(sum);
  endfunction

  function automatic wtab_t build_wtab();
    wtab_t       tab;
    logic [63:0] j;
    logic [63:0] c;
    logic [63:0] v;
    logic        neg;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      neg = (2 * i > COS_TABLE_DEPTH);
      j   = neg ? 64'(COS_TABLE_DEPTH - i) : 64'(i);
      c   = cos_q30((PI_Q30 * j) / 64'(COS_TABLE_DEPTH));
      v   = neg ? (ONE_Q30 - c) : (ONE_Q30 + c);
      tab[i] = WGT_W'((v * 64'd4096 + ONE_Q30) >> 31);
    end
    return tab;
  endfunction

  localparam wtab_t WTAB = build_wtab();

endpackage

// File: design/srcm_if.sv
// Stream and configuration channel interfaces of the spherical mask.
interface srcm_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic signed [31:0] voxel;
  logic signed [31:0] noise;
  modport source (output valid, kind, voxel, noise, input ready);
  modport sink   (input valid, kind, voxel, noise, output ready);
endinterface

interface srcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] voxel_out;
  logic               last;
  modport source (output valid, voxel_out, last, input ready);
  modport sink   (input valid, voxel_out, last, output ready);
endinterface

interface srcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/spherical_raised_cosine_mask.sv
// Top level of the soft spherical raised-cosine mask over a raster-order voxel stream.
// An apply-pass result is loaded into the output register once the voxel is done; a voxel
//   in the band first runs a square root and an index division.
// Throughput: one voxel at a time; input ready returns once the voxel is done, later
//   while the output register is held.
// The last measure-pass voxel adds the 64-step average division.
// Reset: asynchronous, active low; counters, sums and average clear, configuration takes its defaults.
module spherical_raised_cosine_mask
  import srcm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  srcm_in_if.sink    in_i,
  srcm_out_if.source out_o,
  srcm_cfg_if.sink   cfg_i
);

  // Configuration registers
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [RAD_W-1:0]  inner_radius_q;
  logic [EDGE_W-1:0] edge_width_q;
  logic              use_noise_q;

  // Volume state
  logic [POS_W-1:0]        pos_x_q, pos_y_q, pos_z_q;
  logic [WSUM_W-1:0]       wsum_q, wsum_d;
  logic signed [WVS_W-1:0] wvs_q, wvs_d;
  logic signed [VOX_W-1:0] bg_avg_q, bg_avg_d;
  logic                    avg_ready_q, avg_ready_d;

  // Sequencer and per-voxel work registers
  state_e                  state_q, state_d;
  logic [2:0]              mstep_q, mstep_d;
  logic                    kind_q;
  logic signed [VOX_W-1:0] v_q, nz_q;
  logic                    last_item_q;
  logic signed [9:0]       cx_q, cy_q, cz_q;
  logic signed [45:0]      acc_q, acc_d;
  logic [33:0]             rr_q, rr_d;
  logic [WGT_W-1:0]        wq_q, wq_d;
  logic                    inside_q, inside_d;
  logic [VOX_W-1:0]        res_q, res_d;

  // Output register
  logic             out_valid_q;
  logic [VOX_W-1:0] out_vox_q;
  logic             out_last_q;
  logic             out_load;

  // Shared multiplier, registered product
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod_q;

  srcm_cmd_t cmd;
  srcm_sts_t sts;

  // Effective sizes and radii
  logic [SIZE_W-1:0] sx, sy, sz;
  logic [16:0]       rq, rp;
  logic              lx, ly, lz, last_now, in_acc;

  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] s);
    if (s == '0) return SIZE_W'(1);
    if (s > SIZE_W'(MAX_SIZE)) return SIZE_W'(MAX_SIZE);
    return s;
  endfunction

  assign sx = eff_size(size_x_q);
  assign sy = eff_size(size_y_q);
  assign sz = eff_size(size_z_q);

  // Negative radius selects half the x extent
  assign rq = inner_radius_q[RAD_W-1] ? {1'b0, sx, 7'b0} : {1'b0, inner_radius_q[15:0]};
  assign rp = rq + {1'b0, edge_width_q};

  assign lx = ({1'b0, pos_x_q} + SIZE_W'(1)) >= sx;
  assign ly = ({1'b0, pos_y_q} + SIZE_W'(1)) >= sy;
  assign lz = ({1'b0, pos_z_q} + SIZE_W'(1)) >= sz;
  assign last_now = lx & ly & lz;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Configuration writes; unknown indices drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q       <= SIZE_W'(MAX_SIZE);
      size_y_q       <= SIZE_W'(MAX_SIZE);
      size_z_q       <= SIZE_W'(MAX_SIZE);
      inner_radius_q <= '1;
      edge_width_q   <= '0;
      use_noise_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SIZE_X:       size_x_q       <= cfg_i.data[SIZE_W-1:0];
        REG_SIZE_Y:       size_y_q       <= cfg_i.data[SIZE_W-1:0];
        REG_SIZE_Z:       size_z_q       <= cfg_i.data[SIZE_W-1:0];
        REG_INNER_RADIUS: inner_radius_q <= cfg_i.data[RAD_W-1:0];
        REG_EDGE_WIDTH:   edge_width_q   <= cfg_i.data[EDGE_W-1:0];
        REG_USE_NOISE:    use_noise_q    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Position counters advance when a transaction is accepted; each wraps at size-1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (in_acc) begin
      if (lx) begin
        pos_x_q <= '0;
        if (ly) begin
          pos_y_q <= '0;
          pos_z_q <= lz ? '0 : pos_z_q + POS_W'(1);
        end else begin
          pos_y_q <= pos_y_q + POS_W'(1);
        end
      end else begin
        pos_x_q <= pos_x_q + POS_W'(1);
      end
    end
  end

  // Latch the voxel and its centred coordinates
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q      <= in_i.kind;
      v_q         <= in_i.voxel;
      nz_q        <= in_i.noise;
      last_item_q <= last_now;
      cx_q        <= $signed({2'b0, pos_x_q}) - $signed({2'b0, sx[SIZE_W-1:1]});
      cy_q        <= $signed({2'b0, pos_y_q}) - $signed({2'b0, sy[SIZE_W-1:1]});
      cz_q        <= $signed({2'b0, pos_z_q}) - $signed({2'b0, sz[SIZE_W-1:1]});
    end
  end

  // Multiplier operand select
  logic signed [VOX_W-1:0] bg;
  assign bg = use_noise_q ? nz_q : bg_avg_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_GEOM: begin
        unique case (mstep_q)
          3'd0:    begin mul_a = 33'(cx_q); mul_b = 18'(cx_q); end
          3'd1:    begin mul_a = 33'(cy_q); mul_b = 18'(cy_q); end
          3'd2:    begin mul_a = 33'(cz_q); mul_b = 18'(cz_q); end
          3'd3:    begin mul_a = $signed({16'b0, rq}); mul_b = $signed({1'b0, rq}); end
          3'd4:    begin mul_a = $signed({16'b0, rp}); mul_b = $signed({1'b0, rp}); end
          default: ;
        endcase
      end
      ST_MAC: begin
        if (mstep_q == 3'd0) begin
          mul_a = 33'(v_q);
          mul_b = kind_q ? $signed({5'b0, WGT_ONE - wq_q}) : $signed({5'b0, wq_q});
        end else if (mstep_q == 3'd1) begin
          mul_a = 33'(bg);
          mul_b = $signed({5'b0, wq_q});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  srcm_iter u_iter (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts)
  );

  // Band arithmetic and rounding helpers
  logic [33:0]       lhs;
  logic [16:0]       rt, tt;
  logic [IDX_W-1:0]  idx;
  logic [64:0]       sat_sum;
  logic [46:0]       blend;
  logic              avg_neg;
  logic [63:0]       avg_mag, qm;
  logic [32:0]       qclamp;

  always_comb begin
    lhs = {acc_q[17:0], 16'b0};
    rt  = sts.q[16:0];
    tt  = (rt <= rp) ? (rp - rt) : '0;
    if (tt > {1'b0, edge_width_q}) tt = {1'b0, edge_width_q};
    idx = sts.q[IDX_W-1:0];
    if (idx > IDX_W'(COS_TABLE_DEPTH)) idx = IDX_W'(COS_TABLE_DEPTH);
    sat_sum = {wvs_q[WVS_W-1], wvs_q} + 65'(prod_q);
    blend   = 47'(acc_q) + 47'(prod_q) + 47'd2048;
    avg_neg = wvs_q[WVS_W-1];
    avg_mag = avg_neg ? (64'd0 - wvs_q) : wvs_q;
    qm      = sts.q + 64'({sts.rem, 1'b0} >= {2'b0, wsum_q});
    if (qm > 64'h8000_0000) qclamp = 33'h1_0000_0000 >> 1;
    else                    qclamp = qm[32:0];
    if (!avg_neg && qclamp > 33'h0_7FFF_FFFF) qclamp = 33'h0_7FFF_FFFF;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mstep_d     = mstep_q;
    acc_d       = acc_q;
    rr_d        = rr_q;
    wq_d        = wq_q;
    inside_d    = inside_q;
    res_d       = res_q;
    wsum_d      = wsum_q;
    wvs_d       = wvs_q;
    bg_avg_d    = bg_avg_q;
    avg_ready_d = avg_ready_q;
    out_load    = 1'b0;
    cmd         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_GEOM;
          mstep_d = '0;
        end
      end
      ST_GEOM: begin
        mstep_d = mstep_q + 3'd1;
        unique case (mstep_q)
          3'd1:    acc_d = 46'(prod_q);
          3'd2:    acc_d = acc_q + 46'(prod_q);
          3'd3:    acc_d = acc_q + 46'(prod_q);
          3'd4:    rr_d  = prod_q[33:0];
          3'd5: begin
            inside_d = lhs < rr_q;
            mstep_d  = '0;
            if (!(lhs < rr_q) && lhs <= prod_q[33:0] && edge_width_q != '0) begin
              // Soft band: start the square root of the scaled squared distance
              cmd.start = 1'b1;
              cmd.sqrt  = 1'b1;
              cmd.dvd   = {lhs, 30'b0};
              cmd.cnt   = CNT_W'(17);
              state_d   = ST_SQRT;
            end else begin
              wq_d    = WGT_ONE;
              state_d = ST_MAC;
            end
          end
          default: ;
        endcase
      end
      ST_SQRT: begin
        if (!sts.busy) begin
          // Index = round(t*D/W): preload the high part, run the quotient bits
          cmd.start = 1'b1;
          cmd.rem   = REM_W'(tt) + REM_W'(edge_width_q >> IDX_W);
          cmd.dvd   = {edge_width_q[IDX_W-1:0], (64 - IDX_W)'(0)};
          cmd.dsr   = WSUM_W'({edge_width_q, 1'b0});
          cmd.cnt   = CNT_W'(IDX_W);
          state_d   = ST_IDX;
        end
      end
      ST_IDX: begin
        if (!sts.busy) begin
          wq_d    = WTAB[idx];
          state_d = ST_MAC;
          mstep_d = '0;
        end
      end
      ST_MAC: begin
        mstep_d = mstep_q + 3'd1;
        if (!kind_q) begin
          if (inside_q || mstep_q == 3'd1) begin
            if (!inside_q) begin
              wsum_d = wsum_q + WSUM_W'(wq_q);
              if (sat_sum[64] != sat_sum[63]) begin
                wvs_d = sat_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
              end else begin
                wvs_d = sat_sum[63:0];
              end
            end
            state_d = last_item_q ? ST_AVGGO : ST_IDLE;
          end
        end else begin
          if (inside_q) begin
            res_d   = v_q;
            state_d = ST_OUT;
          end else if (mstep_q == 3'd1) begin
            acc_d = 46'(prod_q);
          end else if (mstep_q == 3'd2) begin
            res_d   = blend[43:12];
            state_d = ST_OUT;
          end
        end
      end
      ST_AVGGO: begin
        if (wsum_q == '0) begin
          bg_avg_d    = '0;
          wsum_d      = '0;
          wvs_d       = '0;
          avg_ready_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd.start = 1'b1;
          cmd.dvd   = avg_mag;
          cmd.dsr   = wsum_q;
          cmd.cnt   = CNT_W'(64);
          state_d   = ST_AVG;
        end
      end
      ST_AVG: begin
        if (!sts.busy) begin
          bg_avg_d    = avg_neg ? -qclamp[31:0] : qclamp[31:0];
          wsum_d      = '0;
          wvs_d       = '0;
          avg_ready_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mstep_q     <= '0;
      wsum_q      <= '0;
      wvs_q       <= '0;
      bg_avg_q    <= '0;
      avg_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mstep_q     <= mstep_d;
      wsum_q      <= wsum_d;
      wvs_q       <= wvs_d;
      bg_avg_q    <= bg_avg_d;
      avg_ready_q <= avg_ready_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    rr_q     <= rr_d;
    wq_q     <= wq_d;
    inside_q <= inside_d;
    res_q    <= res_d;
    if (out_load) begin
      out_vox_q  <= res_d;
      out_last_q <= last_item_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.voxel_out = out_vox_q;
  assign out_o.last      = out_last_q;

endmodule

// File: design/srcm_iter.sv
// Shared iterative compare/subtract unit: restoring division and digit-by-digit square root.
module srcm_iter
  import srcm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  srcm_cmd_t cmd_i,
  output srcm_sts_t sts_o
);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              sqrt_q;
  logic [REM_W-1:0]  rem_q;
  logic [63:0]       dvd_q;
  logic [WSUM_W-1:0] dsr_q;
  logic [63:0]       q_q;

  logic [REM_W-1:0]  r2;
  logic [REM_W-1:0]  trial;
  logic              ge;

  always_comb begin
    if (sqrt_q) begin
      r2    = {rem_q[REM_W-3:0], dvd_q[63:62]};
      trial = {q_q[REM_W-3:0], 2'b01};
    end else begin
      r2    = {rem_q[REM_W-2:0], dvd_q[63]};
      trial = {1'b0, dsr_q};
    end
    ge = (r2 >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= cmd_i.cnt;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sqrt_q <= cmd_i.sqrt;
      rem_q  <= cmd_i.rem;
      dvd_q  <= cmd_i.dvd;
      dsr_q  <= cmd_i.dsr;
      q_q    <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (r2 - trial) : r2;
      dvd_q <= sqrt_q ? {dvd_q[61:0], 2'b00} : {dvd_q[62:0], 1'b0};
      q_q   <= {q_q[62:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.q    = q_q;
  assign sts_o.rem  = rem_q;

endmodule
